// ----- rtl/bba_pkg.sv -----
package bba_pkg;

    localparam int MemOrder  = 10;
    localparam int TagBits   = 8;
    localparam int NodeCount = 2 << MemOrder;
    localparam int NodeBits  = MemOrder + 1;
    localparam int TagCount  = 1 << TagBits;
    localparam int OrdBits   = 4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE = 3'd2;
    localparam logic [2:0] ST_NOT_FND  = 3'd3;
    localparam logic [2:0] ST_IN_USE   = 3'd4;

    typedef logic [NodeBits-1:0] t_node;

    // One tree-memory access requested by the sequencer.
    typedef struct packed {
        logic            we;
        t_node           addr;
        logic [OrdBits-1:0] wdata;
    } t_mem_req;

endpackage

// ----- rtl/buddy_block_allocator_top.sv -----
// Operation: a request walks down from the root to a node of its order, splitting
// wholly free nodes on the way; it and a release then climb to the root, updating
// parents and merging free twins. An error skips this; a no fit stops at the root.
// Throughput: one transaction at a time; the next input can be accepted in the cycle after
// the result is taken.
// Reset: synchronous, active low. A sweep then clears all 2048 nodes, with no input taken.
module buddy_block_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_owner_tag,
    input  logic [10:0] i_req_units,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_block_offset,
    output logic [10:0] o_block_units,
    output logic [9:0]  o_internal_frag
);

    localparam int OB = bba_pkg::OrdBits;
    localparam int NB = bba_pkg::NodeBits;
    localparam int MO = bba_pkg::MemOrder;
    localparam int TB = bba_pkg::TagBits;

    // Sequencer states. Every node read is presented in the cycle before its data
    // is used, since the node memory has a registered read port.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROOT  = 4'd1;  // read root
    localparam logic [3:0] S_RWAIT = 4'd2;  // read current node
    localparam logic [3:0] S_DNODE = 4'd3;  // node value ready; maybe split
    localparam logic [3:0] S_DSPL  = 4'd4;  // write right child on split
    localparam logic [3:0] S_DLRD  = 4'd5;  // read left child
    localparam logic [3:0] S_DLWT  = 4'd6;  // hold left child address
    localparam logic [3:0] S_DLEFT = 4'd7;  // pick branch
    localparam logic [3:0] S_LEAF  = 4'd8;  // write target node
    localparam logic [3:0] S_UPL   = 4'd9;  // read left sibling
    localparam logic [3:0] S_UPR   = 4'd10; // read right sibling, left data back
    localparam logic [3:0] S_UPW1  = 4'd11; // hold right sibling address
    localparam logic [3:0] S_UPW2  = 4'd12; // right data back, write parent
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_TAG   = 4'd14; // tag entry back for a release

    logic [3:0]             r_state, n_state;
    bba_pkg::t_mem_req      w_req;
    logic [OB-1:0]          w_rdata;
    logic                   w_busy;

    logic [TB-1:0]          r_tag;
    logic [10:0]            r_units;
    logic                   r_type;
    logic [OB-1:0]          r_k, r_o;
    bba_pkg::t_node         r_n, r_top_n;
    logic [OB-1:0]          r_top_o;
    logic [MO-1:0]          r_off;
    logic [OB-1:0]          r_cur, r_lval;

    logic [bba_pkg::TagCount-1:0] r_valid;

    logic                   w_tag_we;
    logic [TB-1:0]          w_tag_addr;
    logic [MO+OB-1:0]       w_tag_wdata;
    logic [MO+OB-1:0]       w_tag_rdata;
    logic [OB-1:0]          w_t_ord;
    logic [MO-1:0]          w_t_off;

    logic [2:0]             r_status;
    logic [MO-1:0]          r_o_off;
    logic [10:0]            r_o_units;
    logic [MO-1:0]          r_o_frag;

    logic [OB-1:0]          w_k;
    logic [TB-1:0]          w_tag;
    bba_pkg::t_node         w_par;
    logic                   w_accept;
    logic                   w_bad_size;
    logic [2:0]             w_acc_status;

    assign w_tag = i_owner_tag[TB-1:0];
    assign w_par = r_n >> 1;
    assign w_accept = i_valid && o_ready;
    assign w_bad_size = (i_req_units == 11'd0) || (i_req_units > 11'(1 << MO));

    // Order of the smallest power of two holding the request.
    always_comb begin
        w_k = OB'(MO);
        for (int j = MO; j >= 0; j--) begin
            if ((11'(1) << j) >= i_req_units) begin
                w_k = OB'(j);
            end
        end
    end

    // Status decided at acceptance. Size is checked before the tag.
    always_comb begin
        priority if (!i_req_type && w_bad_size) begin
            w_acc_status = bba_pkg::ST_BAD_SIZE;
        end else if (!i_req_type && r_valid[w_tag]) begin
            w_acc_status = bba_pkg::ST_IN_USE;
        end else if (i_req_type && !r_valid[w_tag]) begin
            w_acc_status = bba_pkg::ST_NOT_FND;
        end else begin
            w_acc_status = bba_pkg::ST_OK;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !w_busy;

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_ROOT:  w_req.addr = NB'(1);
            S_RWAIT: w_req.addr = r_n;
            S_DNODE: begin
                // Split a wholly free node on the way down: left half here.
                w_req.addr = r_n << 1;
                w_req.we = (w_rdata == r_o + 1'b1) && (r_o != r_k);
                w_req.wdata = r_o;
            end
            S_DSPL: begin
                w_req.addr = (r_n << 1) | NB'(1);
                w_req.we = (r_cur == r_o + 1'b1);
                w_req.wdata = r_o;
            end
            S_DLRD:  w_req.addr = r_n << 1;
            S_DLWT:  w_req.addr = r_n << 1;
            S_LEAF: begin
                w_req.addr = r_n;
                w_req.we = 1'b1;
                w_req.wdata = r_type ? r_o + 1'b1 : '0;
            end
            S_UPL:   w_req.addr = w_par << 1;
            S_UPR:   w_req.addr = (w_par << 1) | NB'(1);
            S_UPW1:  w_req.addr = (w_par << 1) | NB'(1);
            S_UPW2: begin
                // Two wholly free halves merge into one free parent; else it takes the larger.
                w_req.addr = w_par;
                w_req.we = 1'b1;
                w_req.wdata = (r_lval == r_o + 1'b1 && w_rdata == r_o + 1'b1)
                            ? r_o + 2'd2 : ((r_lval > w_rdata) ? r_lval : w_rdata);
            end
            default: w_req = '0;
        endcase
    end

    bba_tree u_tree (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rdata(w_rdata),
        .o_busy (w_busy)
    );

    // Per-tag offset and order. The entry is read at acceptance and used in the
    // next cycle; it is written when a grant reaches its target node.
    assign w_tag_we    = (r_state == S_LEAF) && !r_type;
    assign w_tag_addr  = (r_state == S_IDLE) ? w_tag : r_tag;
    assign w_tag_wdata = {r_k, r_off};
    assign w_t_ord     = w_tag_rdata[MO+OB-1:MO];
    assign w_t_off     = w_tag_rdata[MO-1:0];

    bba_ram #(
        .Width(MO + OB),
        .Depth(bba_pkg::TagCount)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (w_tag_we),
        .i_addr (w_tag_addr),
        .i_wdata(w_tag_wdata),
        .o_rdata(w_tag_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_acc_status != bba_pkg::ST_OK) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = i_req_type ? S_TAG : S_ROOT;
                    end
                end
            end
            S_ROOT: n_state = S_RWAIT;
            S_RWAIT: n_state = S_DNODE;
            S_DNODE: begin
                priority if (r_n == NB'(1) && w_rdata < r_k + 1'b1) begin
                    n_state = S_OUT;
                end else if (r_o == r_k) begin
                    n_state = S_LEAF;
                end else begin
                    n_state = S_DSPL;
                end
            end
            S_DSPL: n_state = S_DLRD;
            S_DLRD: n_state = S_DLWT;
            S_DLWT: n_state = S_DLEFT;
            S_DLEFT: n_state = S_RWAIT;
            S_TAG: n_state = S_LEAF;
            S_LEAF: n_state = (r_n == NB'(1)) ? S_OUT : S_UPL;
            S_UPL: n_state = S_UPR;
            S_UPR: n_state = S_UPW1;
            S_UPW1: n_state = S_UPW2;
            S_UPW2: n_state = (w_par == NB'(1)) ? S_OUT : S_UPL;
            S_OUT: n_state = i_ready ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_o_off   <= '0;
                        r_o_units <= '0;
                        r_o_frag  <= '0;
                        r_status  <= w_acc_status;
                        r_tag     <= w_tag;
                        r_type    <= i_req_type;
                        r_units   <= i_req_units;
                        r_k       <= w_k;
                        r_n       <= NB'(1);
                        r_o       <= OB'(MO);
                        r_off     <= '0;
                    end
                end
                S_DNODE: begin
                    r_cur <= w_rdata;
                    if (r_n == NB'(1) && w_rdata < r_k + 1'b1) begin
                        r_status <= bba_pkg::ST_NO_FIT;
                    end
                end
                S_DLEFT: begin
                    // Lowest address first: go left whenever the left half fits.
                    r_o <= r_o - 1'b1;
                    if (w_rdata >= r_k + 1'b1) begin
                        r_n <= r_n << 1;
                    end else begin
                        r_n <= (r_n << 1) | NB'(1);
                        r_off <= r_off | MO'(1 << (r_o - 1'b1));
                    end
                end
                S_TAG: begin
                    r_o   <= w_t_ord;
                    r_off <= w_t_off;
                    r_n   <= NB'((NB'(1) << (OB'(MO) - w_t_ord)) + (w_t_off >> w_t_ord));
                end
                S_LEAF: begin
                    r_top_n <= r_n;
                    r_top_o <= r_o;
                    if (!r_type) begin
                        r_valid[r_tag] <= 1'b1;
                        r_o_off   <= r_off;
                        r_o_units <= 11'(1) << r_k;
                        r_o_frag  <= MO'((11'(1) << r_k) - r_units);
                    end else begin
                        r_valid[r_tag] <= 1'b0;
                    end
                end
                S_UPR: r_lval <= w_rdata;
                S_UPW2: begin
                    if (r_lval == r_o + 1'b1 && w_rdata == r_o + 1'b1) begin
                        r_top_n <= w_par;
                        r_top_o <= r_o + 1'b1;
                    end
                    r_o <= r_o + 1'b1;
                    r_n <= w_par;
                end
                default: ;
            endcase
        end
    end

    // Release results take the highest merged node.
    always_comb begin
        o_block_offset = r_o_off;
        o_block_units  = r_o_units;
        if (r_type && r_status == bba_pkg::ST_OK) begin
            o_block_offset = MO'((r_top_n - (NB'(1) << (OB'(MO) - r_top_o))) << r_top_o);
            o_block_units  = 11'(1) << r_top_o;
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_internal_frag = r_o_frag;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while a result waits");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_status))
        else $error("result dropped");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bba_pkg::ST_OK) |-> o_block_units == 11'd0)
        else $error("error result carries a size");
`endif

endmodule

// ----- rtl/bba_ram.sv -----
module bba_ram #(
    parameter int Width = 4,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bba_tree.sv -----
// Node store for the buddy tree. Nodes are cleared by a sweep after reset;
// the root then holds the whole memory as free.
module bba_tree (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_mem_req i_req,
    output logic [bba_pkg::OrdBits-1:0] o_rdata,
    output logic              o_busy
);

    logic                      r_clr;
    bba_pkg::t_node            r_clr_addr;
    logic                      w_we;
    bba_pkg::t_node            w_addr;
    logic [bba_pkg::OrdBits-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == bba_pkg::t_node'(bba_pkg::NodeCount - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr) begin
            w_we    = 1'b1;
            w_addr  = r_clr_addr;
            w_wdata = (r_clr_addr == bba_pkg::t_node'(1))
                    ? bba_pkg::OrdBits'(bba_pkg::MemOrder + 1) : '0;
        end else begin
            w_we    = i_req.we;
            w_addr  = i_req.addr;
            w_wdata = i_req.wdata;
        end
    end

    bba_ram #(
        .Width(bba_pkg::OrdBits),
        .Depth(bba_pkg::NodeCount)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(o_rdata)
    );

    assign o_busy = r_clr;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the buddy block allocator. A behavioral copy of the
// allocation tree predicts every grant and release; a small scoreboard holds
// the predicted results in arrival order and compares each output transaction
// field by field.

typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  offset;
    logic [10:0] units;
    logic [9:0]  frag;
} t_alloc_result;

class alloc_scoreboard;
    t_alloc_result pending_q[$];
    int errors;
    int checked;

    function void note_grant(t_alloc_result r);
        pending_q.push_back(r);
    endfunction

    function void check_result(t_alloc_result got);
        t_alloc_result want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result status=%0d off=%0d units=%0d frag=%0d",
                     $time, got.status, got.offset, got.units, got.frag);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        checked++;
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.offset !== want.offset) begin
            $display("%0t: offset expected %0d actual %0d", $time, want.offset, got.offset);
            errors++;
        end
        if (got.units !== want.units) begin
            $display("%0t: units expected %0d actual %0d", $time, want.units, got.units);
            errors++;
        end
        if (got.frag !== want.frag) begin
            $display("%0t: frag expected %0d actual %0d", $time, want.frag, got.frag);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int Capacity = 1 << bba_pkg::MemOrder;
    localparam int CycleLimit = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [7:0]  owner_tag = '0;
    logic [10:0] req_units = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [9:0]  block_offset;
    logic [10:0] block_units;
    logic [9:0]  internal_frag;

    // Idle patterns: 0 none, 1 sender gaps, 2 receiver stalls, 3 both light.
    int idle_mode = 0;
    int cycles = 0;
    int n_grants = 0;
    int n_releases = 0;
    int n_errs = 0;

    alloc_scoreboard sb;

    // Model of the allocator: largest-free order + 1 per tree node, and the
    // offset and order held by each tag.
    logic [4:0] free_tree [bba_pkg::NodeCount];
    logic       tag_live [bba_pkg::TagCount];
    logic [9:0] tag_off [bba_pkg::TagCount];
    logic [3:0] tag_ord [bba_pkg::TagCount];

    always #5 clk = ~clk;

    buddy_block_allocator_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_req_type(req_type), .i_owner_tag(owner_tag), .i_req_units(req_units),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_status(status), .o_block_offset(block_offset),
        .o_block_units(block_units), .o_internal_frag(internal_frag)
    );

    function automatic void tree_reset();
        foreach (free_tree[i]) free_tree[i] = '0;
        free_tree[1] = 5'(bba_pkg::MemOrder + 1);
        foreach (tag_live[i]) tag_live[i] = 1'b0;
    endfunction

    // Walk up from a changed node, merging twin free halves. Returns the
    // topmost merged node, or the start node if none merged, with its order.
    function automatic void merge_upward(int n, int o, output int top_n, output int top_o);
        int p;
        logic [4:0] l, r;
        top_n = n;
        top_o = o;
        while (n > 1) begin
            p = n >> 1;
            l = free_tree[2*p];
            r = free_tree[2*p+1];
            o++;
            if (l == o && r == o) begin
                free_tree[p] = 5'(o + 1);
                top_n = p;
                top_o = o;
            end else begin
                free_tree[p] = (l > r) ? l : r;
            end
            n = p;
        end
    endfunction

    function automatic t_alloc_result predict_alloc(logic rtype, logic [7:0] tag,
                                                    logic [10:0] req);
        t_alloc_result res;
        int k, n, o, off, tn, to;
        res = '0;
        if (rtype == 1'b0) begin
            if (req == 0 || req > Capacity) begin
                res.status = bba_pkg::ST_BAD_SIZE;
            end else if (tag_live[tag]) begin
                res.status = bba_pkg::ST_IN_USE;
            end else begin
                k = 0;
                while ((1 << k) < req) k++;
                if (free_tree[1] < k + 1) begin
                    res.status = bba_pkg::ST_NO_FIT;
                end else begin
                    n = 1;
                    o = bba_pkg::MemOrder;
                    off = 0;
                    while (o > k) begin
                        // A wholly free node is split into two free halves.
                        if (free_tree[n] == o + 1) begin
                            free_tree[2*n] = 5'(o);
                            free_tree[2*n+1] = 5'(o);
                        end
                        o--;
                        if (free_tree[2*n] >= k + 1) begin
                            n = 2 * n;
                        end else begin
                            n = 2 * n + 1;
                            off += 1 << o;
                        end
                    end
                    free_tree[n] = '0;
                    merge_upward(n, o, tn, to);
                    tag_live[tag] = 1'b1;
                    tag_off[tag] = 10'(off);
                    tag_ord[tag] = 4'(k);
                    res.status = bba_pkg::ST_OK;
                    res.offset = 10'(off);
                    res.units = 11'(1 << k);
                    res.frag = 10'((1 << k) - req);
                end
            end
        end else begin
            if (!tag_live[tag]) begin
                res.status = bba_pkg::ST_NOT_FND;
            end else begin
                k = int'(tag_ord[tag]);
                n = (1 << (bba_pkg::MemOrder - k)) + int'(tag_off[tag] >> k);
                free_tree[n] = 5'(k + 1);
                merge_upward(n, k, tn, to);
                tag_live[tag] = 1'b0;
                res.status = bba_pkg::ST_OK;
                res.offset = 10'((tn - (1 << (bba_pkg::MemOrder - to))) << to);
                res.units = 11'(1 << to);
            end
        end
        return res;
    endfunction

    // Valid is left high after acceptance; the next call replaces the payload
    // at the same edge, or an idle gap or a drain lowers it.
    task automatic send_item(logic rtype, logic [7:0] tag, logic [10:0] req);
        t_alloc_result exp_res;
        if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(99) < ((idle_mode == 1) ? 68 : 6)) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_type <= rtype;
        owner_tag <= tag;
        req_units <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        exp_res = predict_alloc(rtype, tag, req);
        sb.note_grant(exp_res);
        if (rtype) n_releases++; else n_grants++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    // Mostly small requests and releases drawn from a small set of tags, so
    // the tree fills, splits deep and merges back; the rest is noise.
    task automatic random_item();
        int pick;
        logic [7:0] tag;
        logic [10:0] req;
        pick = $urandom_range(99);
        tag = 8'($urandom_range(31));
        if (pick < 8) tag = 8'($urandom_range(255));
        if (pick < 50) begin
            case ($urandom_range(3))
                0: req = 11'($urandom_range(1, 8));
                1: req = 11'($urandom_range(1, 64));
                2: req = 11'($urandom_range(1, 300));
                default: req = 11'($urandom_range(0, 2047));
            endcase
            send_item(1'b0, tag, req);
        end else begin
            send_item(1'b1, tag, 11'($urandom));
        end
    endtask

    // Receiver side: stalls follow the current idle pattern.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                2: out_ready <= ($urandom_range(99) >= 68);
                3: out_ready <= ($urandom_range(99) >= 6);
                default: out_ready <= 1'b1;
            endcase
            if (out_valid && out_ready) begin
                sb.check_result('{status, block_offset, block_units, internal_frag});
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int t;
        sb = new();
        tree_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: size limits, both bad sizes, full capacity, tag reuse,
        // no fit, unknown release, splitting and a merge cascade.
        send_item(1'b0, 8'd0, 11'd0);
        send_item(1'b0, 8'd1, 11'd1025);
        send_item(1'b0, 8'd2, 11'd2047);
        send_item(1'b1, 8'd255, 11'd0);
        send_item(1'b0, 8'd255, 11'd1024);
        send_item(1'b0, 8'd255, 11'd1);
        send_item(1'b0, 8'd3, 11'd1);
        send_item(1'b1, 8'd255, 11'h7ff);
        send_item(1'b0, 8'd10, 11'd1);
        send_item(1'b0, 8'd11, 11'd3);
        send_item(1'b0, 8'd12, 11'd1);
        send_item(1'b0, 8'd13, 11'd513);
        send_item(1'b0, 8'd14, 11'd512);
        send_item(1'b0, 8'd15, 11'd100);
        send_item(1'b0, 8'd16, 11'd512);
        send_item(1'b1, 8'd10, 11'd0);
        send_item(1'b1, 8'd12, 11'd0);
        send_item(1'b1, 8'd11, 11'd0);
        send_item(1'b1, 8'd15, 11'd0);
        send_item(1'b1, 8'd14, 11'd0);
        send_item(1'b1, 8'd14, 11'd0);

        // Sender holds off until every result is back.
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            idle_mode = (ph == 4) ? 0 : ph;
            for (int i = 0; i < 300; i++) random_item();
            wait_drained();
            // Release everything once midway so the later phases start from a
            // clean tree.
            if (ph == 2) begin
                for (t = 0; t < bba_pkg::TagCount; t++) begin
                    if (tag_live[t]) send_item(1'b1, t[7:0], '0);
                end
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        n_errs = sb.errors;
        $display("Covered %0d requests and %0d releases, %0d results checked.",
                 n_grants, n_releases, sb.checked);
        if (n_errs == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
